// ===== rtl/ogtc_pkg.sv =====
// package for the obstacle gate: widths, register indexes, command and status types
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
package ogtc_pkg;
	localparam int TrailDepth = 30;
	localparam int TrailAw = $clog2(TrailDepth);
	localparam int FillW = $clog2(TrailDepth + 1);
	localparam int PosW = 24;
	localparam int DiffW = 25;
	localparam int OffW = 26;
	localparam int SqW = 51;

	localparam logic [2:0] RegIgnDist = 3'd0;
	localparam logic [2:0] RegIgnSpeed = 3'd1;
	localparam logic [2:0] RegLatLim = 3'd2;
	localparam logic [2:0] RegSlowLat = 3'd3;
	localparam logic [2:0] RegSlowSpeed = 3'd4;
	localparam logic [2:0] RegTrailRad = 3'd5;
	localparam logic [2:0] RegTrailSpc = 3'd6;

	typedef struct packed {
		logic load;       // capture input item, compute differences
		logic mul_a;      // rotation products and squares
		logic mul_b;      // shifted product sums
		logic decide;     // evaluate gate rules
		logic pose_upd;   // store pose, read last trail point
		logic pose_chk;   // spacing compare and push
		logic scan_start; // start trail walk
		logic scan_rd;    // read trail entry
		logic scan_cmp;   // compare trail entry
		logic finish;     // load output register
	} ogtc_cmd_t;

	typedef struct packed {
		logic is_pose;
		logic need_scan;
		logic scan_near;
		logic scan_last;
		logic out_busy;
	} ogtc_sts_t;
endpackage

// ===== rtl/obstacle_gate_with_trail_check.sv =====
// top level of the obstacle gate with trail check
// channel       | handshake                 | payload
// s_axis        | s_axis_tvalid/tready      | tdata 112 bit, tuser mode/is_vehicle
// m_axis        | m_axis_tvalid/tready      | tdata 64 bit, tuser keep/behind
// cfg           | cfg_valid/cfg_ready       | cfg_index 3 bit, cfg_data 16 bit
// a pose item passes rotation, pose update, spacing check and output; an obstacle
// rotation, rule check, a trail walk if needed, output; the walk uses one read port
// arst_n clears pose, trail count and handshakes; the trail memory needs no clearing
// a stalled result holds the output register and the block waits before taking more
// depends on ogtc_pkg, ogtc_ctrl, ogtc_dp
`timescale 1ns / 1ps
module obstacle_gate_with_trail_check (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [111:0] s_axis_tdata, // pos_x, pos_y, sin_heading, cos_heading, vel_x, vel_y
	input  logic [7:0]   s_axis_tuser, // mode, is_vehicle
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata, // forward_offset, lateral_offset, trail_count
	output logic [7:0]   m_axis_tuser, // keep, behind
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	ogtc_pkg::ogtc_cmd_t cmd;
	ogtc_pkg::ogtc_sts_t sts;
	logic in_rdy;

	assign s_axis_tready = in_rdy;
	assign cfg_ready = 1'b1;

	ogtc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_axis_tvalid && in_rdy), .in_rdy(in_rdy),
		.cmd(cmd), .sts(sts)
	);

	ogtc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
		.i_mode(s_axis_tuser[0]),
		.i_px(s_axis_tdata[23:0]), .i_py(s_axis_tdata[47:24]),
		.i_sin(s_axis_tdata[63:48]), .i_cos(s_axis_tdata[79:64]),
		.i_vx(s_axis_tdata[95:80]), .i_vy(s_axis_tdata[111:96]),
		.i_veh(s_axis_tuser[1]),
		.o_valid(m_axis_tvalid), .o_ready(m_axis_tready),
		.o_user(m_axis_tuser), .o_data(m_axis_tdata)
	);
endmodule

// port checks of the obstacle gate, attached to the top level by bind
module ogtc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [7:0]  m_axis_tuser,
	input logic        cfg_ready
);
	// a stalled result holds still
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser));

	// padding bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[63:57] == '0) && (m_axis_tuser[7:2] == '0));

	// behind only on a kept item
	a_behind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0]);

	// trail count never above the trail depth
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[56:52] <= 5'(ogtc_pkg::TrailDepth));

	// handshakes are always known
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_axis_tready, m_axis_tvalid, cfg_ready}));
endmodule

bind obstacle_gate_with_trail_check ogtc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .cfg_ready(cfg_ready)
);

// ===== rtl/ogtc_ctrl.sv =====
// controller state machine of the obstacle gate
// depends on ogtc_pkg
`timescale 1ns / 1ps
module ogtc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	output logic               in_rdy,
	output ogtc_pkg::ogtc_cmd_t cmd,
	input  ogtc_pkg::ogtc_sts_t sts
);
	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_MULA  = 10'b0000000010,
		ST_MULB  = 10'b0000000100,
		ST_DEC   = 10'b0000001000,
		ST_PRD   = 10'b0000010000,
		ST_PCHK  = 10'b0000100000,
		ST_SRD   = 10'b0001000000,
		ST_SCMP  = 10'b0010000000,
		ST_FIN   = 10'b0100000000,
		ST_SINIT = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_MULA;
			ST_MULA: state_d = ST_MULB;
			ST_MULB: state_d = sts.is_pose ? ST_PRD : ST_DEC;
			ST_DEC: state_d = sts.need_scan ? ST_SINIT : ST_FIN;
			ST_SINIT: state_d = sts.scan_last ? ST_FIN : ST_SRD;
			ST_SRD: state_d = ST_SCMP;
			ST_SCMP: state_d = (sts.scan_near || sts.scan_last) ? ST_FIN : ST_SRD;
			ST_PRD: state_d = ST_PCHK;
			ST_PCHK: state_d = ST_FIN;
			ST_FIN: if (!sts.out_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		cmd.mul_a = (state_q == ST_MULA);
		cmd.mul_b = (state_q == ST_MULB);
		cmd.decide = (state_q == ST_DEC);
		cmd.scan_start = (state_q == ST_SINIT);
		cmd.scan_rd = (state_q == ST_SRD);
		cmd.scan_cmp = (state_q == ST_SCMP);
		cmd.pose_upd = (state_q == ST_PRD);
		cmd.pose_chk = (state_q == ST_PCHK);
		cmd.finish = (state_q == ST_FIN) && !sts.out_busy;
	end

	assign in_rdy = (state_q == ST_IDLE);
endmodule

// ===== rtl/ogtc_dp.sv =====
// datapath: rotation, gate rules, trail memory and output register
// depends on ogtc_pkg
`timescale 1ns / 1ps
module ogtc_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  ogtc_pkg::ogtc_cmd_t cmd,
	output ogtc_pkg::ogtc_sts_t sts,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [15:0]        cfg_val,
	input  logic               i_mode,
	input  logic signed [23:0] i_px,
	input  logic signed [23:0] i_py,
	input  logic signed [15:0] i_sin,
	input  logic signed [15:0] i_cos,
	input  logic signed [15:0] i_vx,
	input  logic signed [15:0] i_vy,
	input  logic               i_veh,
	output logic               o_valid,
	input  logic               o_ready,
	output logic [7:0]         o_user,
	output logic [63:0]        o_data
);
	localparam int PW = ogtc_pkg::PosW;
	localparam int DW = ogtc_pkg::DiffW;
	localparam int SW = ogtc_pkg::SqW;
	localparam int AW = ogtc_pkg::TrailAw;
	localparam int FW = ogtc_pkg::FillW;
	localparam int OW = ogtc_pkg::OffW;
	localparam int PrW = DW + 16;
	localparam int LatW = PrW - 14 + 1;

	// configuration registers
	logic [15:0] ign_dist_q, lat_lim_q, slow_lat_q, rad_q, spc_q;
	logic [14:0] ign_spd_q, slow_spd_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ign_dist_q <= 16'd15360;
			ign_spd_q <= 15'd4268;
			lat_lim_q <= 16'd5120;
			slow_lat_q <= 16'd1280;
			slow_spd_q <= 15'd256;
			rad_q <= 16'd640;
			spc_q <= 16'd256;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ogtc_pkg::RegIgnDist: ign_dist_q <= cfg_val;
				ogtc_pkg::RegIgnSpeed: ign_spd_q <= cfg_val[14:0];
				ogtc_pkg::RegLatLim: lat_lim_q <= cfg_val;
				ogtc_pkg::RegSlowLat: slow_lat_q <= cfg_val;
				ogtc_pkg::RegSlowSpeed: slow_spd_q <= cfg_val[14:0];
				ogtc_pkg::RegTrailRad: rad_q <= cfg_val;
				ogtc_pkg::RegTrailSpc: spc_q <= cfg_val;
				default: ;
			endcase
		end
	end

	// vehicle pose and trail pointers
	logic signed [PW-1:0] veh_x_q, veh_y_q;
	logic signed [15:0] veh_sin_q, veh_cos_q;
	logic [FW-1:0] fill_q;
	logic [AW-1:0] head_q;

	// captured item
	logic mode_q, veh_flag_q;
	logic signed [PW-1:0] px_q, py_q;
	logic signed [15:0] sin_q, cos_q, vx_q, vy_q;
	logic signed [DW-1:0] ex_q, ey_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= i_mode;
			veh_flag_q <= i_veh;
			px_q <= i_px;
			py_q <= i_py;
			sin_q <= i_sin;
			cos_q <= i_cos;
			vx_q <= i_vx;
			vy_q <= i_vy;
			ex_q <= DW'(i_px) - DW'(veh_x_q);
			ey_q <= DW'(i_py) - DW'(veh_y_q);
		end
	end

	// rotation products and squares: 25x16 products, 25x25 and 16x16 squares
	logic signed [PrW-1:0] p_ec_q, p_es_q, p_nes_q, p_ec2_q;
	logic [SW-1:0] d2_q, s2_q;
	logic signed [LatW-1:0] fwd_q, lat_q;
	logic signed [PrW-1:0] nes;
	assign nes = -(PrW'(ex_q) * PrW'(veh_sin_q));

	always_ff @(posedge clk) begin
		if (cmd.mul_a) begin
			p_ec_q <= PrW'(ex_q) * PrW'(veh_cos_q);
			p_es_q <= PrW'(ey_q) * PrW'(veh_sin_q);
			p_nes_q <= nes;
			p_ec2_q <= PrW'(ey_q) * PrW'(veh_cos_q);
			d2_q <= $unsigned(SW'(ex_q) * SW'(ex_q)) + $unsigned(SW'(ey_q) * SW'(ey_q));
			s2_q <= SW'($unsigned(32'(vx_q) * 32'(vx_q)))
				+ SW'($unsigned(32'(vy_q) * 32'(vy_q)));
		end
		if (cmd.mul_b) begin
			fwd_q <= LatW'(p_ec_q >>> 14) + LatW'(p_es_q >>> 14);
			lat_q <= LatW'(p_nes_q >>> 14) + LatW'(p_ec2_q >>> 14);
		end
	end

	// gate rules
	logic [LatW-1:0] alat;
	logic [31:0] ll_sq, rad_sq, spc_sq, id_sq;
	logic [29:0] ss_sq, is_sq;
	logic keep_d, need_d;
	logic scan_near;
	assign alat = lat_q[LatW-1] ? LatW'(-lat_q) : LatW'(lat_q);
	assign ss_sq = 30'(slow_spd_q) * 30'(slow_spd_q);
	assign is_sq = 30'(ign_spd_q) * 30'(ign_spd_q);
	assign id_sq = 32'(ign_dist_q) * 32'(ign_dist_q);
	assign rad_sq = 32'(rad_q) * 32'(rad_q);
	assign spc_sq = 32'(spc_q) * 32'(spc_q);
	assign ll_sq = 32'(lat_lim_q);

	always_comb begin
		keep_d = 1'b0;
		need_d = 1'b0;
		if (alat > LatW'(lat_lim_q)) keep_d = 1'b0;
		else if (alat > LatW'(slow_lat_q) && s2_q < SW'(ss_sq)) keep_d = 1'b0;
		else if (!veh_flag_q) keep_d = 1'b1;
		else if (d2_q > SW'(id_sq) && s2_q < SW'(is_sq)) keep_d = 1'b0;
		else if (fwd_q[LatW-1] && alat < LatW'(ll_sq)) need_d = 1'b1;
		else keep_d = 1'b1;
	end

	logic keep_q, behind_q, need_q;
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			keep_q <= keep_d;
			behind_q <= 1'b0;
			need_q <= need_d;
		end
		if (cmd.scan_start) begin
			keep_q <= 1'b1;
			behind_q <= 1'b1;
		end
		if (cmd.scan_cmp && scan_near) begin
			keep_q <= 1'b0;
			behind_q <= 1'b0;
		end
		if (cmd.pose_upd) begin
			keep_q <= 1'b0;
			behind_q <= 1'b0;
		end
	end

	// trail memory, one read port with registered data
	logic [2*PW-1:0] trail_mem [ogtc_pkg::TrailDepth];
	logic [2*PW-1:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic mem_we;
	logic [AW-1:0] wr_addr;
	logic [FW-1:0] k_q;
	logic [AW-1:0] sidx_q;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [FW:0] b);
		logic [FW+1:0] s;
		s = (FW+2)'(a) + (FW+2)'(b);
		if (s >= (FW+2)'(ogtc_pkg::TrailDepth)) s = s - (FW+2)'(ogtc_pkg::TrailDepth);
		return AW'(s);
	endfunction

	always_comb begin
		rd_addr = sidx_q;
		if (cmd.pose_upd) rd_addr = wrap_add(head_q, (FW+1)'(fill_q) - (FW+1)'(1));
	end

	always_ff @(posedge clk) begin
		if (cmd.pose_upd || cmd.scan_rd) rd_q <= trail_mem[rd_addr];
		if (mem_we) trail_mem[wr_addr] <= {py_q, px_q};
	end

	// trail walk
	logic signed [DW-1:0] tdx, tdy;
	logic [SW-1:0] td2;
	assign tdx = DW'($signed(rd_q[PW-1:0])) - DW'(px_q);
	assign tdy = DW'($signed(rd_q[2*PW-1:PW])) - DW'(py_q);
	assign td2 = $unsigned(SW'(tdx) * SW'(tdx)) + $unsigned(SW'(tdy) * SW'(tdy));
	assign scan_near = (td2 < SW'(rad_sq));

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			k_q <= '0;
			sidx_q <= head_q;
		end else if (cmd.scan_cmp) begin
			k_q <= k_q + FW'(1);
			sidx_q <= wrap_add(sidx_q, (FW+1)'(1));
		end
	end

	// pose update and push
	logic push;
	assign push = cmd.pose_chk && ((fill_q == '0) || (td2 > SW'(spc_sq)));
	assign mem_we = push;
	assign wr_addr = (fill_q < FW'(ogtc_pkg::TrailDepth)) ?
		wrap_add(head_q, (FW+1)'(fill_q)) : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			veh_x_q <= '0;
			veh_y_q <= '0;
			veh_sin_q <= '0;
			veh_cos_q <= 16'sd16384;
			fill_q <= '0;
			head_q <= '0;
		end else begin
			if (cmd.pose_upd) begin
				veh_x_q <= px_q;
				veh_y_q <= py_q;
				veh_sin_q <= sin_q;
				veh_cos_q <= cos_q;
			end
			if (push) begin
				if (fill_q < FW'(ogtc_pkg::TrailDepth)) fill_q <= fill_q + FW'(1);
				else head_q <= wrap_add(head_q, (FW+1)'(1));
			end
		end
	end

	// output register
	logic o_valid_q;
	logic [7:0] o_user_q;
	logic [63:0] o_data_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) o_valid_q <= 1'b0;
		else if (cmd.finish) o_valid_q <= 1'b1;
		else if (o_ready) o_valid_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			o_user_q <= {6'd0, behind_q, keep_q};
			o_data_q <= mode_q ?
				{7'd0, 5'(fill_q), lat_q[OW-1:0], fwd_q[OW-1:0]} :
				{7'd0, 5'(fill_q), 52'd0};
		end
	end
	assign o_valid = o_valid_q;
	assign o_user = o_user_q;
	assign o_data = o_data_q;

	assign sts.is_pose = !mode_q;
	assign sts.need_scan = need_d;
	assign sts.scan_near = scan_near;
	assign sts.scan_last = cmd.scan_start ? (fill_q == '0) : (k_q == fill_q - FW'(1));
	assign sts.out_busy = o_valid_q && !o_ready;
endmodule

// ===== bench/tb_obstacle_gate_with_trail_check.sv =====
// self-checking bench for the obstacle gate with trail check: pose and obstacle items
// are predicted in the bench and compared with each result; depends on ogtc_pkg and the rtl
`timescale 1ns / 1ps
module tb_obstacle_gate_with_trail_check;
	localparam logic ModePose = 1'b0;
	localparam logic ModeObst = 1'b1;

	typedef struct packed {
		logic        keep;
		logic        behind;
		logic [25:0] fwd;
		logic [25:0] lat;
		logic [4:0]  count;
	} gate_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [111:0] s_axis_tdata = '0;
	logic [7:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic [7:0] m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	obstacle_gate_with_trail_check dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// predictor state
	longint unsigned reg_val [7];
	longint veh_x, veh_y, veh_sin, veh_cos;
	longint trl_x [ogtc_pkg::TrailDepth];
	longint trl_y [ogtc_pkg::TrailDepth];
	int trl_fill, trl_head;
	gate_res_t expected_q [$];
	int errors = 0;
	int n_pose = 0, n_obst = 0, n_kept = 0, n_behind = 0;
	bit no_idle = 1'b0;

	function automatic longint floor_sh14(longint v);
		return v >>> 14;
	endfunction

	function automatic longint absl(longint v);
		return v < 0 ? -v : v;
	endfunction

	task automatic predict_reset();
		reg_val[ogtc_pkg::RegIgnDist] = 15360;
		reg_val[ogtc_pkg::RegIgnSpeed] = 4268;
		reg_val[ogtc_pkg::RegLatLim] = 5120;
		reg_val[ogtc_pkg::RegSlowLat] = 1280;
		reg_val[ogtc_pkg::RegSlowSpeed] = 256;
		reg_val[ogtc_pkg::RegTrailRad] = 640;
		reg_val[ogtc_pkg::RegTrailSpc] = 256;
		veh_x = 0; veh_y = 0; veh_sin = 0; veh_cos = 16384;
		trl_fill = 0; trl_head = 0;
	endtask

	task automatic trail_append(longint x, longint y);
		int slot;
		if (trl_fill < ogtc_pkg::TrailDepth) begin
			slot = (trl_head + trl_fill) % ogtc_pkg::TrailDepth;
			trl_fill++;
		end else begin
			slot = trl_head;
			trl_head = (trl_head + 1) % ogtc_pkg::TrailDepth;
		end
		trl_x[slot] = x;
		trl_y[slot] = y;
	endtask

	// work out the gate decision for one item and update pose and trail
	task automatic predict_gate(logic mode, logic signed [23:0] px24, logic signed [23:0] py24,
			logic signed [15:0] s16, logic signed [15:0] c16, logic signed [15:0] vx16,
			logic signed [15:0] vy16, logic veh);
		gate_res_t r;
		longint px, py, ex, ey, vx, vy, spd2, dist2, fwd, lat, alat, ll, rr, tx, ty, sp;
		int last, idx;
		bit near;
		px = px24; py = py24;
		r = '0;
		fwd = 0; lat = 0;
		if (mode == ModePose) begin
			n_pose++;
			veh_x = px; veh_y = py; veh_sin = s16; veh_cos = c16;
			if (trl_fill == 0) trail_append(px, py);
			else begin
				last = (trl_head + trl_fill - 1) % ogtc_pkg::TrailDepth;
				ex = px - trl_x[last];
				ey = py - trl_y[last];
				sp = reg_val[ogtc_pkg::RegTrailSpc];
				if (ex * ex + ey * ey > sp * sp) trail_append(px, py);
			end
		end else begin
			n_obst++;
			vx = vx16; vy = vy16;
			ex = px - veh_x; ey = py - veh_y;
			spd2 = vx * vx + vy * vy;
			dist2 = ex * ex + ey * ey;
			ll = reg_val[ogtc_pkg::RegLatLim];
			fwd = floor_sh14(ex * veh_cos) + floor_sh14(ey * veh_sin);
			lat = floor_sh14(-(ex * veh_sin)) + floor_sh14(ey * veh_cos);
			alat = absl(lat);
			if (alat > ll) r.keep = 1'b0;
			else if (alat > longint'(reg_val[ogtc_pkg::RegSlowLat]) &&
					spd2 < longint'(reg_val[ogtc_pkg::RegSlowSpeed] *
						reg_val[ogtc_pkg::RegSlowSpeed]))
				r.keep = 1'b0;
			else if (!veh) r.keep = 1'b1;
			else if (dist2 > longint'(reg_val[ogtc_pkg::RegIgnDist] *
						reg_val[ogtc_pkg::RegIgnDist]) &&
					spd2 < longint'(reg_val[ogtc_pkg::RegIgnSpeed] *
						reg_val[ogtc_pkg::RegIgnSpeed]))
				r.keep = 1'b0;
			else if (fwd < 0 && lat < ll && lat > -ll) begin
				rr = reg_val[ogtc_pkg::RegTrailRad];
				near = 1'b0;
				for (int k = 0; k < trl_fill; k++) begin
					idx = (trl_head + k) % ogtc_pkg::TrailDepth;
					tx = trl_x[idx] - px;
					ty = trl_y[idx] - py;
					if (tx * tx + ty * ty < rr * rr) near = 1'b1;
				end
				r.keep = !near;
				r.behind = !near;
			end else r.keep = 1'b1;
			if (r.keep) n_kept++;
			if (r.behind) n_behind++;
		end
		r.fwd = fwd[25:0];
		r.lat = lat[25:0];
		r.count = trl_fill[4:0];
		expected_q.insert(expected_q.size(), r);
	endtask

	// idle gap on the input side, dropping tvalid for its length
	task automatic random_idle();
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// send one item and predict its result
	task automatic send_item(logic mode, logic signed [23:0] px, logic signed [23:0] py,
			logic signed [15:0] s, logic signed [15:0] c, logic signed [15:0] vx,
			logic signed [15:0] vy, logic veh);
		random_idle();
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= {6'd0, veh, mode};
		s_axis_tdata <= {vy, vx, c, s, py, px};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_gate(mode, px, py, s, c, vx, vy, veh);
	endtask

	task automatic write_reg(logic [2:0] index, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		reg_val[index] = (index == ogtc_pkg::RegIgnSpeed || index == ogtc_pkg::RegSlowSpeed) ?
			value & 16'h7FFF : value;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
	endtask

	// compare each result with the oldest expectation
	initial begin
		gate_res_t want;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) report_mismatch("unexpected item", 1, 0);
				else begin
					want = expected_q[0];
					expected_q.delete(0);
					if (m_axis_tuser[0] !== want.keep)
						report_mismatch("keep", m_axis_tuser[0], want.keep);
					if (m_axis_tuser[1] !== want.behind)
						report_mismatch("behind", m_axis_tuser[1], want.behind);
					if (m_axis_tdata[25:0] !== want.fwd)
						report_mismatch("forward_offset", m_axis_tdata[25:0], want.fwd);
					if (m_axis_tdata[51:26] !== want.lat)
						report_mismatch("lateral_offset", m_axis_tdata[51:26], want.lat);
					if (m_axis_tdata[56:52] !== want.count)
						report_mismatch("trail_count", m_axis_tdata[56:52], want.count);
				end
			end
		end
	end

	// receiver stalls in bursts
	initial begin
		forever begin
			@(posedge clk);
			if (!no_idle && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 5) - 1) @(posedge clk);
			end else m_axis_tready <= 1'b1;
		end
	end

	// random obstacle near the vehicle, mostly inside the gating ranges
	task automatic send_near_obstacle();
		logic signed [23:0] px, py;
		px = 24'(veh_x + $signed($urandom_range(0, 16000)) - 8000);
		py = 24'(veh_y + $signed($urandom_range(0, 16000)) - 8000);
		send_item(ModeObst, px, py, 0, 0, 16'($urandom), 16'($urandom),
			$urandom_range(0, 3) != 0);
	endtask

	task automatic send_near_pose();
		logic signed [23:0] px, py;
		int ang;
		longint s, c;
		px = 24'(veh_x + $signed($urandom_range(0, 1200)) - 600);
		py = 24'(veh_y + $signed($urandom_range(0, 1200)) - 600);
		ang = $urandom_range(0, 3);
		s = (ang == 1) ? 16384 : (ang == 3) ? -16384 : $signed($urandom_range(0, 32768)) - 16384;
		c = (ang == 0) ? 16384 : (ang == 2) ? -16384 : $signed($urandom_range(0, 32768)) - 16384;
		send_item(ModePose, px, py, 16'(s), 16'(c), 16'($urandom), 16'($urandom),
			1'($urandom));
	endtask

	task automatic test_directed_extremes();
		// trail of eight poses, then obstacles ahead of the vehicle on and off the trail
		for (int k = 0; k < 8; k++)
			send_item(ModePose, 24'(-k * 300), 0, 0, 16384, 0, 0, 0);
		send_item(ModeObst, -24'sd600, 24'sd10, 0, 0, 0, 0, 1);
		send_item(ModeObst, -24'sd1000, 24'sd900, 0, 0, 0, 0, 1);
		send_item(ModeObst, 24'sd1000, 24'sd0, 0, 0, 16'sd1000, 0, 0);
		send_item(ModeObst, 24'sd0, 24'sd6000, 0, 0, 0, 0, 1);
		send_item(ModeObst, 24'sd0, 24'sd2000, 0, 0, 16'sd10, 0, 0);
		send_item(ModeObst, 24'sd20000, 24'sd0, 0, 0, 16'sd100, 0, 1);
		// field extremes and out of range heading
		send_item(ModePose, 24'sh7FFFFF, 24'sh800000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
			16'sh8000, 1);
		send_item(ModeObst, 24'sh800000, 24'sh7FFFFF, 16'hFFFF, 16'hFFFF, 16'sh8000,
			16'sh7FFF, 1);
		send_item(ModeObst, 24'sh7FFFFF, 24'sh800000, 0, 0, 16'sh7FFF, 16'sh8000, 0);
		send_item(ModePose, 24'sh800000, 24'sh7FFFFF, 16'sh8000, 16'sh7FFF, 0, 0, 0);
		send_item(ModeObst, 24'sh000000, 24'sh000000, 0, 0, 0, 0, 1);
		send_item(ModePose, 0, 0, 0, 16384, 0, 0, 0);
		wait_drained();
	endtask

	task automatic test_random_traffic(int count);
		cfg_valid <= 1'b0;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 19) == 0)
				send_item(1'($urandom), 24'($urandom), 24'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
			else if ($urandom_range(0, 2) == 0) send_near_pose();
			else send_near_obstacle();
		end
		wait_drained();
	endtask

	task automatic test_register_settings();
		write_reg(ogtc_pkg::RegIgnDist, 16'hFFFF);
		write_reg(ogtc_pkg::RegIgnSpeed, 16'h7FFF);
		write_reg(ogtc_pkg::RegLatLim, 16'hFFFF);
		write_reg(ogtc_pkg::RegSlowLat, 16'h0000);
		write_reg(ogtc_pkg::RegSlowSpeed, 16'h0000);
		write_reg(ogtc_pkg::RegTrailRad, 16'hFFFF);
		write_reg(ogtc_pkg::RegTrailSpc, 16'h0000);
		test_random_traffic(80);
		write_reg(ogtc_pkg::RegIgnDist, 16'h0000);
		write_reg(ogtc_pkg::RegIgnSpeed, 16'h0000);
		write_reg(ogtc_pkg::RegLatLim, 16'h0000);
		write_reg(ogtc_pkg::RegSlowLat, 16'hFFFF);
		write_reg(ogtc_pkg::RegSlowSpeed, 16'h7FFF);
		write_reg(ogtc_pkg::RegTrailRad, 16'h0000);
		write_reg(ogtc_pkg::RegTrailSpc, 16'hFFFF);
		test_random_traffic(40);
		for (int i = 0; i < 7; i++) write_reg(3'(i), 16'($urandom_range(200, 9000)));
		test_random_traffic(60);
	endtask

	initial begin
		#200_000_000;
		$display("tb_obstacle_gate_with_trail_check NOT OK");
		$finish;
	end

	initial begin
		predict_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed_extremes();
		test_random_traffic(140);
		test_register_settings();
		no_idle = 1'b1;
		test_random_traffic(80);
		$display("covered %0d pose and %0d obstacle items, %0d kept, %0d behind",
			n_pose, n_obst, n_kept, n_behind);
		if (errors == 0) $display("tb_obstacle_gate_with_trail_check OK");
		else $display("tb_obstacle_gate_with_trail_check NOT OK");
		$finish;
	end
endmodule
